>>> src/slcc_pkg.sv
package slcc_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned SecW = 10;
  localparam int unsigned TickW = 16;
  localparam int unsigned ArgProdW = 14;

  localparam logic [SecW-1:0] ArgSat = 10'd1023;

  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChVt    = 8'h0B;
  localparam logic [7:0] ChFf    = 8'h0C;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  localparam logic [SecW-1:0]  HoldMinRst = 10'd1;
  localparam logic [SecW-1:0]  HoldMaxRst = 10'd600;
  localparam logic [TickW-1:0] SettleRst  = 16'd100;
  localparam logic [TickW-1:0] PulseRst   = 16'd50;
  localparam logic [TickW-1:0] TpsRst     = 16'd1000;

  typedef enum logic [0:0] {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    REPLY_NONE    = 3'd0,
    REPLY_PONG    = 3'd1,
    REPLY_VERSION = 3'd2,
    REPLY_OK      = 3'd3,
    REPLY_BUSY    = 3'd4,
    REPLY_RANGE   = 3'd5,
    REPLY_UNKNOWN = 3'd6,
    REPLY_TOOLONG = 3'd7
  } reply_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HOLD_MIN = 3'd0,
    CFG_HOLD_MAX = 3'd1,
    CFG_SETTLE   = 3'd2,
    CFG_PULSE    = 3'd3,
    CFG_TPS      = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ARG_SKIP   = 2'd0,
    ARG_DIGITS = 2'd1,
    ARG_DONE   = 2'd2
  } arg_phase_e;

  typedef enum logic [2:0] {
    RLY_IDLE         = 3'd0,
    RLY_OPEN_SETTLE  = 3'd1,
    RLY_OPEN_PULSE   = 3'd2,
    RLY_OPEN_AFTER   = 3'd3,
    RLY_HOLD         = 3'd4,
    RLY_CLOSE_SETTLE = 3'd5,
    RLY_CLOSE_PULSE  = 3'd6
  } relay_phase_e;

  function automatic logic [7:0] kw_ping(input logic [1:0] idx);
    logic [7:0] ch;
    unique case (idx)
      2'd0:    ch = 8'h50;
      2'd1:    ch = 8'h49;
      2'd2:    ch = 8'h4E;
      default: ch = 8'h47;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] kw_ver(input logic [1:0] idx);
    logic [7:0] ch;
    unique case (idx)
      2'd0:    ch = 8'h56;
      2'd1:    ch = 8'h45;
      2'd2:    ch = 8'h52;
      default: ch = 8'h56;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] kw_open(input logic [1:0] idx);
    logic [7:0] ch;
    unique case (idx)
      2'd0:    ch = 8'h4F;
      2'd1:    ch = 8'h50;
      2'd2:    ch = 8'h45;
      default: ch = 8'h4E;
    endcase
    return ch;
  endfunction

  function automatic logic [TickW-1:0] at_least_one(input logic [TickW-1:0] v);
    return (v == '0) ? TickW'(1) : v;
  endfunction

endpackage

>>> src/slcc_if.sv
interface slcc_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] rx_byte;

  modport source (output valid, output op, output rx_byte, input ready);
  modport sink (input valid, input op, input rx_byte, output ready);
endinterface

interface slcc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] reply;
  logic       relay_dir;
  logic       relay_pulse;
  logic       lock_busy;

  modport source (output valid, output reply, output relay_dir, output relay_pulse,
                  output lock_busy, input ready);
  modport sink (input valid, input reply, input relay_dir, input relay_pulse,
                input lock_busy, output ready);
endinterface

interface slcc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [slcc_pkg::CfgIdxW-1:0]  index;
  logic [slcc_pkg::CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> src/serial_lock_command_controller_top.sv
// Serial lock command controller. Each input transfer is a received serial byte
// (op 0) or a one-millisecond tick (op 1), and each one yields exactly one result
// transfer with a reply code and the relay direction, relay pulse and busy levels
// after that item. Bytes build CR/LF-terminated lines matched against PING, VER and
// OPEN <seconds>; an accepted OPEN drives the latching relay through open pulse,
// hold and close pulse, timed in ticks. The line and relay state update in a single
// pass between the input handshake and the result register, so a new item is
// taken every cycle while the result side keeps up.
// Configuration writes are taken at any time and must only come while idle.
module serial_lock_command_controller_top #(
  parameter int unsigned LINE_BUFFER = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  slcc_in_if.sink     in_i,
  slcc_out_if.source  out_o,
  slcc_cfg_if.sink    cfg_i
);

  localparam int unsigned LenW = $clog2(LINE_BUFFER);
  localparam logic [LenW-1:0] LenMax = LenW'(LINE_BUFFER - 1);

  // config registers
  logic [slcc_pkg::SecW-1:0]  hold_min_q, hold_max_q;
  logic [slcc_pkg::TickW-1:0] settle_q, pulse_q, tps_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_min_q <= slcc_pkg::HoldMinRst;
      hold_max_q <= slcc_pkg::HoldMaxRst;
      settle_q   <= slcc_pkg::SettleRst;
      pulse_q    <= slcc_pkg::PulseRst;
      tps_q      <= slcc_pkg::TpsRst;
    end else if (cfg_i.valid) begin
      unique case (slcc_pkg::cfg_idx_e'(cfg_i.index))
        slcc_pkg::CFG_HOLD_MIN: hold_min_q <= cfg_i.data[slcc_pkg::SecW-1:0];
        slcc_pkg::CFG_HOLD_MAX: hold_max_q <= cfg_i.data[slcc_pkg::SecW-1:0];
        slcc_pkg::CFG_SETTLE:   settle_q   <= cfg_i.data;
        slcc_pkg::CFG_PULSE:    pulse_q    <= cfg_i.data;
        slcc_pkg::CFG_TPS:      tps_q      <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // line and relay state
  logic [LenW-1:0]             len_q, len_d;
  logic                        ping_q, ping_d, ver_q, ver_d, open_q, open_d;
  logic                        ended_q, ended_d, neg_q, neg_d;
  slcc_pkg::arg_phase_e        argph_q, argph_d;
  logic [slcc_pkg::SecW-1:0]   arg_q, arg_d;
  slcc_pkg::relay_phase_e      rly_q, rly_d;
  logic [slcc_pkg::TickW-1:0]  cnt_q, cnt_d;
  logic [slcc_pkg::SecW-1:0]   hold_q, hold_d;

  // result register
  logic                        out_valid_q, out_valid_d;
  slcc_pkg::reply_e            reply_q, reply_d;
  logic                        dir_q, dir_d, pulse_out_q, pulse_out_d, busy_q, busy_d;

  logic                        in_xfer;
  logic [7:0]                  ch;
  logic                        is_digit, is_blank;
  logic [3:0]                  dval;
  logic [slcc_pkg::ArgProdW-1:0] prod;
  logic [slcc_pkg::TickW-1:0]  cnt_inc, limit;
  logic                        pm, vm, om;

  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign in_xfer     = in_i.valid && in_i.ready;
  assign ch          = in_i.rx_byte;
  assign is_digit    = (ch >= slcc_pkg::ChZero) && (ch <= slcc_pkg::ChNine);
  assign is_blank    = (ch == slcc_pkg::ChSpace) || (ch == slcc_pkg::ChTab) ||
                       (ch == slcc_pkg::ChVt) || (ch == slcc_pkg::ChFf);
  assign dval        = 4'(ch - slcc_pkg::ChZero);
  assign prod        = slcc_pkg::ArgProdW'(arg_q) * slcc_pkg::ArgProdW'(10) +
                       slcc_pkg::ArgProdW'(dval);
  assign cnt_inc     = cnt_q + slcc_pkg::TickW'(1);

  always_comb begin
    limit = slcc_pkg::at_least_one(settle_q);
    unique case (rly_q)
      slcc_pkg::RLY_OPEN_PULSE, slcc_pkg::RLY_CLOSE_PULSE:
        limit = slcc_pkg::at_least_one(pulse_q);
      slcc_pkg::RLY_HOLD:
        limit = slcc_pkg::at_least_one(tps_q);
      default: ;
    endcase
  end

  always_comb begin
    len_d   = len_q;
    ping_d  = ping_q;
    ver_d   = ver_q;
    open_d  = open_q;
    ended_d = ended_q;
    neg_d   = neg_q;
    argph_d = argph_q;
    arg_d   = arg_q;
    rly_d   = rly_q;
    cnt_d   = cnt_q;
    hold_d  = hold_q;
    reply_d = reply_q;
    pm      = ping_q;
    vm      = ver_q;
    om      = open_q;

    if (in_xfer) begin
      reply_d = slcc_pkg::REPLY_NONE;
      if (in_i.op == slcc_pkg::OP_TICK) begin
        unique case (rly_q)
          slcc_pkg::RLY_IDLE: ;
          slcc_pkg::RLY_HOLD: begin
            cnt_d = cnt_inc;
            if (cnt_inc >= limit) begin
              cnt_d = '0;
              if (hold_q != '0) hold_d = hold_q - slcc_pkg::SecW'(1);
              if (hold_q <= slcc_pkg::SecW'(1)) rly_d = slcc_pkg::RLY_CLOSE_SETTLE;
            end
          end
          slcc_pkg::RLY_OPEN_SETTLE, slcc_pkg::RLY_OPEN_PULSE, slcc_pkg::RLY_OPEN_AFTER,
          slcc_pkg::RLY_CLOSE_SETTLE, slcc_pkg::RLY_CLOSE_PULSE: begin
            cnt_d = cnt_inc;
            if (cnt_inc >= limit) begin
              cnt_d = '0;
              priority case (rly_q)
                slcc_pkg::RLY_OPEN_AFTER:
                  rly_d = (hold_q == '0) ? slcc_pkg::RLY_CLOSE_SETTLE : slcc_pkg::RLY_HOLD;
                slcc_pkg::RLY_CLOSE_PULSE:
                  rly_d = slcc_pkg::RLY_IDLE;
                default:
                  rly_d = slcc_pkg::relay_phase_e'(rly_q + 3'd1);
              endcase
            end
          end
          default: begin
            rly_d = slcc_pkg::RLY_IDLE;
            cnt_d = '0;
          end
        endcase
      end else if (ch == slcc_pkg::ChLf || ch == slcc_pkg::ChCr) begin
        if (len_q != '0) begin
          if (!ended_q) begin
            pm = ping_q && (len_q == LenW'(4));
            vm = ver_q && (len_q == LenW'(3));
            om = open_q && (len_q >= LenW'(4));
          end
          priority if (pm) begin
            reply_d = slcc_pkg::REPLY_PONG;
          end else if (vm) begin
            reply_d = slcc_pkg::REPLY_VERSION;
          end else if (!om) begin
            reply_d = slcc_pkg::REPLY_UNKNOWN;
          end else if (rly_q != slcc_pkg::RLY_IDLE) begin
            reply_d = slcc_pkg::REPLY_BUSY;
          end else if ((neg_q && arg_q != '0) || arg_q < hold_min_q || arg_q > hold_max_q) begin
            reply_d = slcc_pkg::REPLY_RANGE;
          end else begin
            reply_d = slcc_pkg::REPLY_OK;
            hold_d  = arg_q;
            rly_d   = slcc_pkg::RLY_OPEN_SETTLE;
            cnt_d   = '0;
          end
          len_d   = '0;
          ping_d  = 1'b1;
          ver_d   = 1'b1;
          open_d  = 1'b1;
          ended_d = 1'b0;
          argph_d = slcc_pkg::ARG_SKIP;
          neg_d   = 1'b0;
          arg_d   = '0;
        end
      end else if (len_q >= LenMax) begin
        reply_d = slcc_pkg::REPLY_TOOLONG;
        len_d   = '0;
        ping_d  = 1'b1;
        ver_d   = 1'b1;
        open_d  = 1'b1;
        ended_d = 1'b0;
        argph_d = slcc_pkg::ARG_SKIP;
        neg_d   = 1'b0;
        arg_d   = '0;
      end else begin
        len_d = len_q + LenW'(1);
        if (!ended_q) begin
          if (ch == slcc_pkg::ChNul) begin
            ping_d  = ping_q && (len_q == LenW'(4));
            ver_d   = ver_q && (len_q == LenW'(3));
            if (len_q < LenW'(4)) open_d = 1'b0;
            ended_d = 1'b1;
          end else begin
            ping_d = ping_q && (len_q < LenW'(4)) && (ch == slcc_pkg::kw_ping(len_q[1:0]));
            ver_d  = ver_q && (len_q < LenW'(3)) && (ch == slcc_pkg::kw_ver(len_q[1:0]));
            if (len_q < LenW'(4)) begin
              open_d = open_q && (ch == slcc_pkg::kw_open(len_q[1:0]));
            end else if (len_q == LenW'(4)) begin
              open_d = open_q && (ch == slcc_pkg::ChSpace);
            end else begin
              unique case (argph_q)
                slcc_pkg::ARG_SKIP: begin
                  priority if (is_blank) begin
                    argph_d = slcc_pkg::ARG_SKIP;
                  end else if (ch == slcc_pkg::ChPlus || ch == slcc_pkg::ChMinus) begin
                    neg_d   = (ch == slcc_pkg::ChMinus);
                    argph_d = slcc_pkg::ARG_DIGITS;
                  end else if (is_digit) begin
                    arg_d   = slcc_pkg::SecW'(dval);
                    argph_d = slcc_pkg::ARG_DIGITS;
                  end else begin
                    argph_d = slcc_pkg::ARG_DONE;
                  end
                end
                slcc_pkg::ARG_DIGITS: begin
                  if (is_digit) begin
                    arg_d = (prod > slcc_pkg::ArgProdW'(slcc_pkg::ArgSat)) ?
                            slcc_pkg::ArgSat : prod[slcc_pkg::SecW-1:0];
                  end else begin
                    argph_d = slcc_pkg::ARG_DONE;
                  end
                end
                default: ;
              endcase
            end
          end
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    dir_d       = dir_q;
    pulse_out_d = pulse_out_q;
    busy_d      = busy_q;
    if (in_xfer) begin
      out_valid_d = 1'b1;
      dir_d       = (rly_d == slcc_pkg::RLY_OPEN_SETTLE) || (rly_d == slcc_pkg::RLY_OPEN_PULSE) ||
                    (rly_d == slcc_pkg::RLY_OPEN_AFTER);
      pulse_out_d = (rly_d == slcc_pkg::RLY_OPEN_PULSE) || (rly_d == slcc_pkg::RLY_CLOSE_PULSE);
      busy_d      = (rly_d != slcc_pkg::RLY_IDLE);
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      ping_q      <= 1'b1;
      ver_q       <= 1'b1;
      open_q      <= 1'b1;
      ended_q     <= 1'b0;
      neg_q       <= 1'b0;
      argph_q     <= slcc_pkg::ARG_SKIP;
      arg_q       <= '0;
      rly_q       <= slcc_pkg::RLY_IDLE;
      cnt_q       <= '0;
      hold_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      ping_q      <= ping_d;
      ver_q       <= ver_d;
      open_q      <= open_d;
      ended_q     <= ended_d;
      neg_q       <= neg_d;
      argph_q     <= argph_d;
      arg_q       <= arg_d;
      rly_q       <= rly_d;
      cnt_q       <= cnt_d;
      hold_q      <= hold_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    reply_q     <= reply_d;
    dir_q       <= dir_d;
    pulse_out_q <= pulse_out_d;
    busy_q      <= busy_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.reply       = reply_q;
  assign out_o.relay_dir   = dir_q;
  assign out_o.relay_pulse = pulse_out_q;
  assign out_o.lock_busy   = busy_q;

endmodule
